[design/ffa_pkg.sv]
// ----------------------------------------------------------------------------
// ffa_pkg
// shared types and constants of the first-fit free-list allocator
// ----------------------------------------------------------------------------
`default_nettype none
package ffa_pkg;
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int OUT_CNT_W     = 11;

    localparam logic [31:0] PAGE_ROUND_ADD  = 32'h0000_0fff;
    localparam logic [31:0] PAGE_ROUND_MASK = 32'hffff_f000;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_LOST    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_CHECK, S_DECIDE, S_WRITE,
        S_DN, S_DN_WR, S_UP, S_UP_WR, S_FIN, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_RD_SCAN, OP_ADVANCE, OP_DECIDE, OP_WRITE,
        OP_DN_RD, OP_DN_WR, OP_UP_RD, OP_UP_WR, OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        ACT_FAIL, ACT_WRITE, ACT_WRITE_REMOVE, ACT_REMOVE, ACT_INSERT, ACT_DROP
    } t_act;

    typedef struct packed {
        logic scan_end;
        logic hit;
        logic dn_more;
        logic up_more;
        t_act act;
    } t_stat;
endpackage
`default_nettype wire

[design/ffa_ctrl.sv]
// ----------------------------------------------------------------------------
// ffa_ctrl
// sequencer for scan, update, shift and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none
module ffa_ctrl import ffa_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  wire   i_slot_free,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output logic  o_out_load,
    output t_op   o_op
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = S_DECIDE;
                end else begin
                    o_op    = OP_RD_SCAN;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.hit) begin
                    n_state = S_DECIDE;
                end else begin
                    o_op    = OP_ADVANCE;
                    n_state = S_SCAN;
                end
            end
            S_DECIDE: begin
                o_op = OP_DECIDE;
                n_state = S_FIN;
            end
            S_FIN: begin
                // entered once after decide: dispatch on the chosen action
                case (i_stat.act)
                    ACT_WRITE, ACT_WRITE_REMOVE: n_state = S_WRITE;
                    ACT_REMOVE:                  n_state = S_DN;
                    ACT_INSERT:                  n_state = S_UP;
                    default: begin
                        o_op    = OP_FINISH;
                        n_state = S_OUT;
                    end
                endcase
            end
            S_WRITE: begin
                o_op = OP_WRITE;
                if (i_stat.act == ACT_WRITE_REMOVE) begin
                    n_state = S_DN;
                end else begin
                    n_state = S_OUT;
                    o_op    = OP_WRITE;
                end
            end
            S_DN: begin
                if (i_stat.dn_more) begin
                    o_op    = OP_DN_RD;
                    n_state = S_DN_WR;
                end else begin
                    o_op    = OP_FINISH;
                    n_state = S_OUT;
                end
            end
            S_DN_WR: begin
                o_op    = OP_DN_WR;
                n_state = S_DN;
            end
            S_UP: begin
                if (i_stat.up_more) begin
                    o_op    = OP_UP_RD;
                    n_state = S_UP_WR;
                end else begin
                    o_op    = OP_WRITE;
                    n_state = S_OUT;
                end
            end
            S_UP_WR: begin
                o_op    = OP_UP_WR;
                n_state = S_UP;
            end
            S_OUT: begin
                if (i_slot_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[design/ffa_dpath.sv]
// ----------------------------------------------------------------------------
// ffa_dpath
// region table memory, scan pointers, merge logic and counters
// ----------------------------------------------------------------------------
`default_nettype none
module ffa_dpath import ffa_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_op                  i_op,
    input  wire [1:0]            i_mode,
    input  wire [31:0]           i_block_addr,
    input  wire [31:0]           i_block_size,
    output t_stat                o_stat,
    output logic [31:0]          o_alloc_addr,
    output logic [1:0]           o_status,
    output logic [31:0]          o_free_total,
    output logic [OUT_CNT_W-1:0] o_entries_used,
    output logic [OUT_CNT_W-1:0] o_peak_entries,
    output logic [31:0]          o_lost_count,
    output logic [31:0]          o_lost_bytes
);
    logic [63:0]      r_mem [TABLE_ENTRIES];
    logic [63:0]      r_rd;
    logic [IDX_W-1:0] rd_addr;
    logic             we;

    logic             r_alloc;
    logic [31:0]      r_addr, r_size;
    logic [CNT_W-1:0] r_idx, r_ptr, r_count, r_peak;
    logic             r_prev_ok;
    logic [31:0]      r_prev_s, r_prev_l;
    t_act             r_act, n_act;
    logic [CNT_W-1:0] r_wa, n_wa;
    logic [63:0]      r_wd, n_wd;
    logic [31:0]      r_grant, n_grant;
    logic [1:0]       r_status;
    logic [31:0]      r_total, r_lost_n, r_lost_b;

    logic [31:0] cur_s, cur_l, size_in;
    logic        in_range, prev_m, next_m;

    assign cur_s    = r_rd[31:0];
    assign cur_l    = r_rd[63:32];
    assign in_range = (r_idx < r_count);
    assign prev_m   = r_prev_ok && ((r_prev_s + r_prev_l) == r_addr);
    assign next_m   = in_range && ((r_addr + r_size) == cur_s);
    assign size_in  = i_mode[1] ? ((i_block_size + PAGE_ROUND_ADD) & PAGE_ROUND_MASK)
                                : i_block_size;

    always_comb begin
        n_act   = ACT_FAIL;
        n_wa    = r_idx;
        n_wd    = {r_size, r_addr};
        n_grant = 32'd0;
        if (r_alloc) begin
            if (in_range) begin
                n_grant = cur_s;
                if (cur_l == r_size) begin
                    n_act = ACT_REMOVE;
                end else begin
                    n_act = ACT_WRITE;
                    n_wd  = {cur_l - r_size, cur_s + r_size};
                end
            end
        end else if (prev_m) begin
            n_wa = r_idx - CNT_W'(1);
            if (next_m) begin
                n_act = ACT_WRITE_REMOVE;
                n_wd  = {r_prev_l + r_size + cur_l, r_prev_s};
            end else begin
                n_act = ACT_WRITE;
                n_wd  = {r_prev_l + r_size, r_prev_s};
            end
        end else if (next_m) begin
            n_act = ACT_WRITE;
            n_wd  = {cur_l + r_size, r_addr};
        end else if (r_count < CNT_W'(TABLE_ENTRIES)) begin
            n_act = ACT_INSERT;
        end else begin
            n_act = ACT_DROP;
        end
    end

    always_comb begin
        case (i_op)
            OP_DN_RD: rd_addr = r_ptr[IDX_W-1:0] + IDX_W'(1);
            OP_UP_RD: rd_addr = r_ptr[IDX_W-1:0] - IDX_W'(1);
            default:  rd_addr = r_idx[IDX_W-1:0];
        endcase
    end
    assign we = (i_op == OP_WRITE) || (i_op == OP_DN_WR) || (i_op == OP_UP_WR);

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            if (i_op == OP_WRITE) begin
                r_mem[r_wa[IDX_W-1:0]] <= r_wd;
            end else begin
                r_mem[r_ptr[IDX_W-1:0]] <= r_rd;
            end
        end
    end

    // payload of the current request, scan position, decided write and shift pointer
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_alloc   <= ~i_mode[0];
                r_addr    <= i_block_addr;
                r_size    <= size_in;
                r_idx     <= '0;
                r_prev_ok <= 1'b0;
            end
            OP_ADVANCE: begin
                r_prev_s  <= cur_s;
                r_prev_l  <= cur_l;
                r_prev_ok <= 1'b1;
                r_idx     <= r_idx + CNT_W'(1);
            end
            OP_DECIDE: begin
                r_wa    <= n_wa;
                r_wd    <= n_wd;
                r_grant <= n_grant;
                r_ptr   <= (n_act == ACT_INSERT) ? r_count : r_idx;
            end
            OP_DN_WR: r_ptr <= r_ptr + CNT_W'(1);
            OP_UP_WR: r_ptr <= r_ptr - CNT_W'(1);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= ACT_FAIL;
            r_status <= ST_OK;
            r_count  <= '0;
            r_peak   <= '0;
            r_total  <= '0;
            r_lost_n <= '0;
            r_lost_b <= '0;
        end else begin
            if (i_op == OP_DECIDE) begin
                r_act <= n_act;
                case (n_act)
                    ACT_FAIL: r_status <= ST_NO_FIT;
                    ACT_DROP: r_status <= ST_LOST;
                    default:  r_status <= ST_OK;
                endcase
                if (n_act != ACT_FAIL && n_act != ACT_DROP) begin
                    r_total <= r_alloc ? (r_total - r_size) : (r_total + r_size);
                end
            end
            // count changes only once shifting is over
            if (i_op == OP_FINISH || (i_op == OP_WRITE && r_act == ACT_INSERT)) begin
                case (r_act)
                    ACT_REMOVE, ACT_WRITE_REMOVE: r_count <= r_count - CNT_W'(1);
                    ACT_INSERT: begin
                        r_count <= r_count + CNT_W'(1);
                        if (r_peak < r_count + CNT_W'(1)) begin
                            r_peak <= r_count + CNT_W'(1);
                        end
                    end
                    ACT_DROP: begin
                        r_lost_n <= r_lost_n + 32'd1;
                        r_lost_b <= r_lost_b + r_size;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_stat.scan_end = ~in_range;
    assign o_stat.hit      = r_alloc ? (cur_l >= r_size) : (cur_s > r_addr);
    assign o_stat.dn_more  = (r_ptr + CNT_W'(1)) < r_count;
    assign o_stat.up_more  = r_ptr > r_idx;
    assign o_stat.act      = r_act;

    assign o_alloc_addr   = r_grant;
    assign o_status       = r_status;
    assign o_free_total   = r_total;
    assign o_entries_used = OUT_CNT_W'(r_count);
    assign o_peak_entries = OUT_CNT_W'(r_peak);
    assign o_lost_count   = r_lost_n;
    assign o_lost_bytes   = r_lost_b;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_ENTRIES)) else $error("entry count above table size");
    a_peak_ge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_count) else $error("peak below entry count");
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_DECIDE && n_act == ACT_DROP) |-> r_count == CNT_W'(TABLE_ENTRIES))
        else $error("free dropped with room left");
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_WRITE && r_act == ACT_INSERT) |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow table");
endmodule
`default_nettype wire

[design/first_fit_free_list_allocator_unit.sv]
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_unit
// first-fit allocator over an address-sorted free region table with coalescing
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (lsb first)
// s_axis   in   mode[1:0] block_addr[33:2] block_size[65:34], zero pad to 72
// m_axis   out  alloc_addr status free_total entries_used peak_entries
//               lost_count lost_bytes, 152 bits
//
// a request scans table entries in order, each read and then checked, then for a
// remove or insert shifts entries, each read and then written back; scan and
// shift together cover at most the whole table
// one word is worked on at a time; the next is taken once the result is queued
// the result register holds its word while m_axis_tready is low
// i_rst_n (synchronous) empties the table and clears all counters
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_free_list_allocator_unit import ffa_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [71:0]  s_axis_tdata,  // mode, block_addr, block_size
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [151:0] m_axis_tdata   // alloc_addr, status, free_total,
                                        // entries_used, peak_entries,
                                        // lost_count, lost_bytes
);
    t_op   op;
    t_stat stat;
    logic  out_load;
    logic  [151:0] res;
    logic  [151:0] r_out;
    logic  r_out_v;

    ffa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_slot_free (~r_out_v | m_axis_tready),
        .i_stat      (stat),
        .o_in_ready  (s_axis_tready),
        .o_out_load  (out_load),
        .o_op        (op)
    );

    ffa_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .i_mode         (s_axis_tdata[1:0]),
        .i_block_addr   (s_axis_tdata[33:2]),
        .i_block_size   (s_axis_tdata[65:34]),
        .o_stat         (stat),
        .o_alloc_addr   (res[31:0]),
        .o_status       (res[33:32]),
        .o_free_total   (res[65:34]),
        .o_entries_used (res[76:66]),
        .o_peak_entries (res[87:77]),
        .o_lost_count   (res[119:88]),
        .o_lost_bytes   (res[151:120])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_load) begin
            r_out_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;
endmodule
`default_nettype wire
